### src/utf8_validating_decoder_assert.svh
// Assertion macros shared by the decoder RTL; they expect clk and rst_n in scope.
`ifndef UTF8_VALIDATING_DECODER_ASSERT_SVH
`define UTF8_VALIDATING_DECODER_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define UVD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define UVD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/u8dec_pkg.sv
// Package for the UTF-8 decoder: item types, constants and lead byte classification.
`default_nettype none

package u8dec_pkg;

    localparam int unsigned CP_W = 21;

    localparam logic [CP_W-1:0] REPL_CP   = 21'h00FFFD;
    localparam logic [CP_W-1:0] MIN_CP_2  = 21'h000080;
    localparam logic [CP_W-1:0] MIN_CP_3  = 21'h000800;
    localparam logic [CP_W-1:0] MIN_CP_4  = 21'h010000;
    localparam logic [CP_W-1:0] SURR_LO   = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI   = 21'h00DFFF;
    localparam logic [CP_W-1:0] MAX_CP    = 21'h10FFFF;

    localparam logic [2:0] SEQ_LEN_2 = 3'd2;
    localparam logic [2:0] SEQ_LEN_3 = 3'd3;
    localparam logic [2:0] SEQ_LEN_4 = 3'd4;

    // Input item: one raw byte plus end-of-stream mark
    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } byte_item_t;

    // Result item: one code point
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            replaced;
        logic            run_last;
    } cp_item_t;

    // Decoder sequence state
    typedef struct packed {
        logic [1:0] held_count;
        logic [2:0] seq_len;
    } seq_state_t;

    // What one byte does: holding buffer write, next state and result run
    typedef struct packed {
        logic            wr_en;
        logic [1:0]      wr_idx;
        seq_state_t      state_next;
        logic [2:0]      res_cnt;
        logic [CP_W-1:0] res_cp;
        logic            res_rep;
    } step_res_t;

    typedef enum logic [2:0] {
        LEAD_ASCII = 3'd0,
        LEAD_TWO   = 3'd1,
        LEAD_THREE = 3'd2,
        LEAD_FOUR  = 3'd3,
        LEAD_BAD   = 3'd4
    } lead_kind_t;

    // Classify a byte seen where a lead is expected
    function automatic lead_kind_t lead_kind(input logic [7:0] b);
        lead_kind_t k;
        priority if (b[7] == 1'b0)       k = LEAD_ASCII;
        else if (b[7:5] == 3'b110)       k = LEAD_TWO;
        else if (b[7:4] == 4'b1110)      k = LEAD_THREE;
        else if (b[7:3] == 5'b11110)     k = LEAD_FOUR;
        else                             k = LEAD_BAD;
        return k;
    endfunction

    // Expected sequence length for a multi-byte lead
    function automatic logic [2:0] lead_len(input lead_kind_t k);
        logic [2:0] len;
        unique case (k)
            LEAD_TWO:   len = SEQ_LEN_2;
            LEAD_THREE: len = SEQ_LEN_3;
            LEAD_FOUR:  len = SEQ_LEN_4;
            default:    len = 3'd0;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

### src/u8dec_step.sv
// Per-byte decode logic: given the held sequence and a new byte, the results and next state.
`default_nettype none

module u8dec_step (
    input  u8dec_pkg::byte_item_t item,
    input  u8dec_pkg::seq_state_t state,
    input  logic [7:0]            held0,
    input  logic [7:0]            held1,
    input  logic [7:0]            held2,
    output u8dec_pkg::step_res_t  res
);

    logic [7:0]                   b;
    logic                         is_cont;
    logic                         is_held;
    logic                         completes;
    logic [2:0]                   held_w;
    logic [u8dec_pkg::CP_W-1:0]   cp2;
    logic [u8dec_pkg::CP_W-1:0]   cp3;
    logic [u8dec_pkg::CP_W-1:0]   cp4;
    logic [u8dec_pkg::CP_W-1:0]   fin_cp;
    logic                         fin_bad;
    u8dec_pkg::lead_kind_t        kind;

    assign b         = item.data_byte;
    assign is_cont   = (b[7:6] == 2'b10);
    assign held_w    = {1'b0, state.held_count};
    assign is_held   = (state.held_count != 2'd0);
    assign completes = ((held_w + 3'd1) >= state.seq_len) || (state.held_count == 2'd3);
    assign kind      = u8dec_pkg::lead_kind(b);

    // Assemble the finished code point; the new byte is always the last one
    assign cp2 = {10'd0, held0[4:0], b[5:0]};
    assign cp3 = {5'd0, held0[3:0], held1[5:0], b[5:0]};
    assign cp4 = {held0[2:0], held1[5:0], held2[5:0], b[5:0]};

    // Range checks: overlong, surrogate, beyond the last plane
    always_comb
    begin
        unique case (state.seq_len)
            u8dec_pkg::SEQ_LEN_2:
            begin
                fin_cp  = cp2;
                fin_bad = (cp2 < u8dec_pkg::MIN_CP_2);
            end
            u8dec_pkg::SEQ_LEN_3:
            begin
                fin_cp  = cp3;
                fin_bad = (cp3 < u8dec_pkg::MIN_CP_3)
                       || ((cp3 >= u8dec_pkg::SURR_LO) && (cp3 <= u8dec_pkg::SURR_HI));
            end
            u8dec_pkg::SEQ_LEN_4:
            begin
                fin_cp  = cp4;
                fin_bad = (cp4 < u8dec_pkg::MIN_CP_4) || (cp4 > u8dec_pkg::MAX_CP);
            end
            default:
            begin
                fin_cp  = u8dec_pkg::REPL_CP;
                fin_bad = 1'b1;
            end
        endcase
    end

    // Results and state update; every result but the last is a replacement
    always_comb
    begin
        res.wr_en      = 1'b0;
        res.wr_idx     = state.held_count;
        res.state_next = state;
        res.res_cnt    = 3'd0;
        res.res_cp     = u8dec_pkg::REPL_CP;
        res.res_rep    = 1'b1;

        if (is_held && is_cont)
        begin
            if (completes)
            begin
                res.res_cnt    = 3'd1;
                res.res_cp     = fin_bad ? u8dec_pkg::REPL_CP : fin_cp;
                res.res_rep    = fin_bad;
                res.state_next = '0;
            end
            else
            begin
                res.wr_en                 = 1'b1;
                res.state_next.held_count = state.held_count + 2'd1;
                // truncated at end of stream: one replacement per held byte, this one included
                if (item.stream_end)
                begin
                    res.res_cnt    = held_w + 3'd1;
                    res.state_next = '0;
                end
            end
        end
        else
        begin
            // broken sequence flushes first, then the byte is a lead
            res.state_next = '0;
            unique case (kind)
                u8dec_pkg::LEAD_ASCII:
                begin
                    res.res_cnt = held_w + 3'd1;
                    res.res_cp  = {13'd0, b};
                    res.res_rep = 1'b0;
                end
                u8dec_pkg::LEAD_TWO,
                u8dec_pkg::LEAD_THREE,
                u8dec_pkg::LEAD_FOUR:
                begin
                    res.wr_en  = 1'b1;
                    res.wr_idx = 2'd0;
                    if (item.stream_end)
                    begin
                        res.res_cnt = held_w + 3'd1;
                    end
                    else
                    begin
                        res.res_cnt               = held_w;
                        res.state_next.held_count = 2'd1;
                        res.state_next.seq_len    = u8dec_pkg::lead_len(kind);
                    end
                end
                default:
                begin
                    res.res_cnt = held_w + 3'd1;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### src/utf8_validating_decoder.sv
// Top level of the UTF-8 validating decoder: input register, sequence state, result run register.
//
//  Channel  | Ports                               | Item
//  ---------+-------------------------------------+---------------------------------------
//  bytes in | byte_valid, byte_stall, byte_item   | data_byte, stream_end
//  cps out  | cp_valid, cp_stall, cp_item         | code_point, replaced, run_last
//
// A byte is taken every cycle unless byte_stall is high and passes the input register, then
// the result register. A byte giving n code points (0 to 4) holds the single result register
// until all n leave, one leaving per cycle while cp_stall is low, so error bursts push back on
// the input. A byte giving no code point passes without waiting for the result register.
// Reset clears the input and result valids and the sequence state; held bytes need none.
`default_nettype none

module utf8_validating_decoder (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_stall,
    input  u8dec_pkg::byte_item_t byte_item,
    output logic                  cp_valid,
    input  logic                  cp_stall,
    output u8dec_pkg::cp_item_t   cp_item
);

`include "utf8_validating_decoder_assert.svh"

    logic                         in_valid_reg;
    u8dec_pkg::byte_item_t        in_item_reg;
    u8dec_pkg::seq_state_t        state_reg;
    logic [7:0]                   held_bytes_reg [0:2];
    logic                         res_valid_reg;
    logic [2:0]                   res_left_reg;
    logic [u8dec_pkg::CP_W-1:0]   res_cp_reg;
    logic                         res_rep_reg;

    u8dec_pkg::step_res_t         step;
    logic                         out_take;
    logic                         res_free;
    logic                         adv;
    logic                         byte_take;
    logic                         res_load;
    logic                         on_last;

    // Decode of the registered byte
    u8dec_step u_step (
        .item  (in_item_reg),
        .state (state_reg),
        .held0 (held_bytes_reg[0]),
        .held1 (held_bytes_reg[1]),
        .held2 (held_bytes_reg[2]),
        .res   (step)
    );

    // Handshake glue
    assign out_take   = res_valid_reg && !cp_stall;
    assign on_last    = (res_left_reg == 3'd1);
    assign res_free   = !res_valid_reg || (out_take && on_last);
    assign adv        = in_valid_reg && (res_free || (step.res_cnt == 3'd0));
    assign res_load   = adv && (step.res_cnt != 3'd0);
    assign byte_stall = in_valid_reg && !adv;
    assign byte_take  = byte_valid && !byte_stall;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!byte_stall)
        begin
            in_valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_take)
        begin
            in_item_reg <= byte_item;
        end
    end

    // Sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (adv)
        begin
            state_reg <= step.state_next;
        end
    end

    // Held lead and continuation bytes
    always_ff @(posedge clk)
    begin
        if (adv && step.wr_en)
        begin
            held_bytes_reg[step.wr_idx] <= in_item_reg.data_byte;
        end
    end

    // Result run: count of code points still to deliver
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            res_left_reg  <= 3'd0;
        end
        else if (res_load)
        begin
            res_valid_reg <= 1'b1;
            res_left_reg  <= step.res_cnt;
        end
        else if (out_take)
        begin
            res_valid_reg <= !on_last;
            res_left_reg  <= res_left_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_cp_reg  <= step.res_cp;
            res_rep_reg <= step.res_rep;
        end
    end

    // Output: leading results of a run are replacements
    assign cp_valid           = res_valid_reg;
    assign cp_item.run_last   = on_last;
    assign cp_item.code_point = on_last ? res_cp_reg : u8dec_pkg::REPL_CP;
    assign cp_item.replaced   = on_last ? res_rep_reg : 1'b1;

    // Checks
    `UVD_ASSERT_NOW(a_state_consistent, 1'b1, ((state_reg.held_count == 2'd0) == (state_reg.seq_len == 3'd0)) && ((state_reg.held_count == 2'd0) || ({1'b0, state_reg.held_count} < state_reg.seq_len)), "held count and sequence length disagree")
    `UVD_ASSERT_NOW(a_stall_cause, byte_stall, in_valid_reg && res_valid_reg, "input stalled with no pending results")
    `UVD_ASSERT_NEXT(a_run_continues, out_take && !on_last, res_valid_reg, "result run ended early")
    `UVD_ASSERT_NOW(a_run_length, res_valid_reg, (res_left_reg != 3'd0) && (res_left_reg <= 3'd4), "bad result run length")

endmodule

`default_nettype wire
